@@ hw/rtl/rfpc_pkg.sv @@
// Shared constants, types and helpers for the ring FIFO with peek and commit.
package rfpc_pkg;

  // Storage geometry.
  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxWidth  = $clog2(Depth);
  localparam int unsigned CntWidth  = $clog2(Depth + 1);

  // Port field widths.
  localparam int unsigned ModeWidth = 3;
  localparam int unsigned RdWidth   = 32;
  localparam int unsigned LenWidth  = 5;
  localparam int unsigned DepthRegWidth = 5;

  // Configuration port geometry.
  localparam int unsigned PaddrWidth = 3;
  localparam int unsigned PdataWidth = 32;

  // Register indexes.
  localparam logic RegDepthInUse = 1'b0;

  // Operation codes carried in the mode field.
  localparam logic [ModeWidth-1:0] ModeEnqueue = 3'd0;
  localparam logic [ModeWidth-1:0] ModeDequeue = 3'd1;
  localparam logic [ModeWidth-1:0] ModePeek    = 3'd2;
  localparam logic [ModeWidth-1:0] ModeCommit  = 3'd3;
  localparam logic [ModeWidth-1:0] ModeRewind  = 3'd4;
  localparam logic [ModeWidth-1:0] ModeQuery   = 3'd5;

  // Configuration handed from the register block to the queue core.
  typedef struct packed {
    logic                clear;
    logic [CntWidth-1:0] depth;
  } cfg_t;

  // Step a ring index forward, wrapping at the depth in use.
  function automatic logic [IdxWidth-1:0] advance(input logic [IdxWidth-1:0] idx,
                                                  input logic [CntWidth-1:0] depth);
    logic [CntWidth-1:0] nxt;
    nxt = CntWidth'(idx) + CntWidth'(1);
    if (nxt >= depth) begin
      advance = '0;
    end else begin
      advance = nxt[IdxWidth-1:0];
    end
  endfunction

  // Bring a written depth into the legal range of one to Depth.
  function automatic logic [CntWidth-1:0] clamp_depth(input logic [DepthRegWidth-1:0] val);
    logic [DepthRegWidth-1:0] d;
    d = val;
    if (d == '0) begin
      d = DepthRegWidth'(1);
    end
    if (d > DepthRegWidth'(Depth)) begin
      d = DepthRegWidth'(Depth);
    end
    clamp_depth = CntWidth'(d);
  endfunction

endpackage

@@ hw/rtl/rfpc_if.sv @@
// Valid/ready channel interfaces for operation words and result words.
interface rfpc_in_if;
  logic                                valid;
  logic                                ready;
  logic [rfpc_pkg::ModeWidth-1:0]      mode;
  logic [rfpc_pkg::DataWidth-1:0]      write_data;

  modport source (output valid, output mode, output write_data, input ready);
  modport sink   (input valid, input mode, input write_data, output ready);
endinterface

interface rfpc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic [rfpc_pkg::RdWidth-1:0]        read_data;
  logic [rfpc_pkg::LenWidth-1:0]       length;

  modport source (output valid, output ok, output read_data, output length, input ready);
  modport sink   (input valid, input ok, input read_data, input length, output ready);
endinterface

@@ hw/rtl/rfpc_regs.sv @@
// APB-style register block holding the depth in use.
module rfpc_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rfpc_pkg::PaddrWidth-1:0] paddr,
  input  logic [rfpc_pkg::PdataWidth-1:0] pwdata,
  output logic [rfpc_pkg::PdataWidth-1:0] prdata,
  output logic                            pready,
  output rfpc_pkg::cfg_t                  cfg_o
);

  logic [rfpc_pkg::CntWidth-1:0] depth_q, depth_d;
  logic                          sel_depth;
  logic                          wr_depth;

  // Decode the register index from the word address.
  assign sel_depth = (paddr[rfpc_pkg::PaddrWidth-1:2] == rfpc_pkg::RegDepthInUse);
  assign wr_depth  = psel && penable && pwrite && sel_depth;
  assign pready    = 1'b1;

  // Next depth, clamped into range on a write.
  always_comb begin
    depth_d = depth_q;
    if (wr_depth) begin
      depth_d = rfpc_pkg::clamp_depth(pwdata[rfpc_pkg::DepthRegWidth-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= rfpc_pkg::CntWidth'(rfpc_pkg::Depth);
    end else begin
      depth_q <= depth_d;
    end
  end

  // Read back the register value.
  assign prdata = sel_depth ? rfpc_pkg::PdataWidth'(depth_q) : '0;

  // A write to the depth empties the queue.
  assign cfg_o.clear = wr_depth;
  assign cfg_o.depth = depth_q;

endmodule

@@ hw/rtl/rfpc_core.sv @@
// Queue core: input register, pointer update with entry memory, result register.
module rfpc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rfpc_pkg::cfg_t   cfg_i,
  rfpc_in_if.sink          in_i,
  rfpc_out_if.source       out_o
);

  // Input register.
  logic                               in_valid_q;
  logic [rfpc_pkg::ModeWidth-1:0]     in_mode_q;
  logic [rfpc_pkg::DataWidth-1:0]     in_data_q;

  // Queue state.
  logic [rfpc_pkg::IdxWidth-1:0]      head_q, head_d;
  logic [rfpc_pkg::IdxWidth-1:0]      tail_q, tail_d;
  logic [rfpc_pkg::IdxWidth-1:0]      peek_q, peek_d;
  logic [rfpc_pkg::CntWidth-1:0]      count_q, count_d;
  logic [rfpc_pkg::CntWidth-1:0]      pcount_q, pcount_d;
  logic [rfpc_pkg::DataWidth-1:0]     mem_q [rfpc_pkg::Depth];

  // Result register.
  logic                               out_valid_q;
  logic                               out_ok_q, ok_d;
  logic [rfpc_pkg::DataWidth-1:0]     out_data_q;
  logic [rfpc_pkg::CntWidth-1:0]      out_len_q;

  logic                               fire;
  logic                               do_enq;
  logic                               do_read;
  logic [rfpc_pkg::IdxWidth-1:0]      rd_addr;

  // The held word is processed whenever the result register is free or drains.
  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_mode_q <= in_i.mode;
      in_data_q <= in_i.write_data;
    end
  end

  // Operation decode and next pointer state.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    peek_d   = peek_q;
    count_d  = count_q;
    pcount_d = pcount_q;
    ok_d     = 1'b0;
    do_enq   = 1'b0;
    do_read  = 1'b0;
    rd_addr  = peek_q;
    case (in_mode_q)
      rfpc_pkg::ModeEnqueue: begin
        if (count_q < cfg_i.depth) begin
          do_enq   = 1'b1;
          tail_d   = rfpc_pkg::advance(tail_q, cfg_i.depth);
          count_d  = count_q + rfpc_pkg::CntWidth'(1);
          pcount_d = pcount_q + rfpc_pkg::CntWidth'(1);
          ok_d     = 1'b1;
        end
      end
      rfpc_pkg::ModeDequeue: begin
        rd_addr = head_q;
        if (count_q != '0) begin
          do_read  = 1'b1;
          head_d   = rfpc_pkg::advance(head_q, cfg_i.depth);
          count_d  = count_q - rfpc_pkg::CntWidth'(1);
          peek_d   = head_d;
          pcount_d = count_d;
          ok_d     = 1'b1;
        end
      end
      rfpc_pkg::ModePeek: begin
        if (pcount_q != '0) begin
          do_read  = 1'b1;
          peek_d   = rfpc_pkg::advance(peek_q, cfg_i.depth);
          pcount_d = pcount_q - rfpc_pkg::CntWidth'(1);
          ok_d     = 1'b1;
        end
      end
      rfpc_pkg::ModeCommit: begin
        head_d  = peek_q;
        count_d = pcount_q;
        ok_d    = 1'b1;
      end
      rfpc_pkg::ModeRewind: begin
        peek_d   = head_q;
        pcount_d = count_q;
        ok_d     = 1'b1;
      end
      rfpc_pkg::ModeQuery: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Pointer registers; a depth write empties the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      peek_q   <= '0;
      count_q  <= '0;
      pcount_q <= '0;
    end else if (cfg_i.clear) begin
      head_q   <= '0;
      tail_q   <= '0;
      peek_q   <= '0;
      count_q  <= '0;
      pcount_q <= '0;
    end else if (fire) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      peek_q   <= peek_d;
      count_q  <= count_d;
      pcount_q <= pcount_d;
    end
  end

  // Entry memory with one write port and a registered read into the result.
  always_ff @(posedge clk_i) begin
    if (fire && do_enq) begin
      mem_q[tail_q] <= in_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_ok_q   <= ok_d;
      out_len_q  <= count_d;
      out_data_q <= do_read ? mem_q[rd_addr] : '0;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.ok        = out_ok_q;
  assign out_o.read_data = rfpc_pkg::RdWidth'(out_data_q);
  assign out_o.length    = rfpc_pkg::LenWidth'(out_len_q);

endmodule

@@ hw/rtl/ring_fifo_with_peek_commit_top.sv @@
// Top level of the ring FIFO with peek and commit.
//
//   Channel   Direction  Contents
//   in_i      sink       mode, write_data (operation word)
//   out_o     source     ok, read_data, length (result word)
//   APB       slave      depth_in_use register at byte address 0
//
// One operation word is taken per cycle unless a stalled result blocks it; each
// gives one result word through the input register and then the result register.
// The pointer update and the entry memory read lie between those two registers.
// Reset empties the queue and sets the depth to sixteen; entries are not cleared.
// A stalled result holds both stages, and input is taken again as it drains.
module ring_fifo_with_peek_commit_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rfpc_in_if.sink                         in_i,
  rfpc_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rfpc_pkg::PaddrWidth-1:0] paddr,
  input  logic [rfpc_pkg::PdataWidth-1:0] pwdata,
  output logic [rfpc_pkg::PdataWidth-1:0] prdata,
  output logic                            pready
);

  rfpc_pkg::cfg_t cfg;

  // Configuration registers.
  rfpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Queue datapath.
  rfpc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

@@ verif/ring_fifo_with_peek_commit_top_tb.sv @@
// Testbench for the ring FIFO with peek and commit: directed and random traffic, checked word by word.
`timescale 1ns / 100ps

module ring_fifo_with_peek_commit_top_tb;
  import rfpc_pkg::*;

  // Spare mode codes that the block must reject.
  localparam logic [ModeWidth-1:0] ModeSpareLow  = 3'd6;
  localparam logic [ModeWidth-1:0] ModeSpareHigh = 3'd7;

  // Byte address of the depth register: four bytes per register index.
  localparam logic [PaddrWidth-1:0] DepthRegAddr = {RegDepthInUse, 2'b00};

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldOffCycles = 120;

  typedef struct packed {
    logic                ok;
    logic [RdWidth-1:0]  read_data;
    logic [LenWidth-1:0] length;
  } result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PaddrWidth-1:0] paddr;
  logic [PdataWidth-1:0] pwdata;
  logic [PdataWidth-1:0] prdata;
  logic                  pready;

  rfpc_in_if  op_if ();
  rfpc_out_if res_if ();

  ring_fifo_with_peek_commit_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (op_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted queue state.
  logic [DataWidth-1:0] ring_store [Depth];
  logic [IdxWidth-1:0]  head_slot;
  logic [IdxWidth-1:0]  tail_slot;
  logic [IdxWidth-1:0]  peek_slot;
  logic [CntWidth-1:0]  held_count;
  logic [CntWidth-1:0]  peekable_count;
  logic [CntWidth-1:0]  ring_depth;

  // Result words still to come, oldest first.
  result_t awaited_results [$];

  int unsigned cycle_count;
  int          failures;
  int          ops_sent;
  int          words_checked;
  int          depth_writes;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_off_req;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Step a ring slot forward, wrapping at the depth in use.
  function automatic logic [IdxWidth-1:0] wrap_next(input logic [IdxWidth-1:0] slot);
    logic [CntWidth-1:0] nxt;
    nxt = CntWidth'(slot) + CntWidth'(1);
    if (nxt >= ring_depth) begin
      return '0;
    end
    return nxt[IdxWidth-1:0];
  endfunction

  function automatic void empty_ring();
    head_slot      = '0;
    tail_slot      = '0;
    peek_slot      = '0;
    held_count     = '0;
    peekable_count = '0;
  endfunction

  // A depth write is clamped to one..Depth and empties the queue.
  function automatic void take_depth_write(input logic [PdataWidth-1:0] value);
    logic [DepthRegWidth-1:0] d;
    d = value[DepthRegWidth-1:0];
    if (d == '0) begin
      d = DepthRegWidth'(1);
    end
    if (d > DepthRegWidth'(Depth)) begin
      d = DepthRegWidth'(Depth);
    end
    ring_depth = CntWidth'(d);
    empty_ring();
  endfunction

  // Apply one operation to the predicted queue and return its result word.
  function automatic result_t apply_queue_op(input logic [ModeWidth-1:0] mode,
                                             input logic [DataWidth-1:0] data);
    result_t r;
    r = '0;
    case (mode)
      ModeEnqueue: begin
        if (held_count < ring_depth) begin
          ring_store[tail_slot] = data;
          tail_slot = wrap_next(tail_slot);
          held_count++;
          peekable_count++;
          r.ok = 1'b1;
        end
      end
      ModeDequeue: begin
        if (held_count != '0) begin
          r.read_data = RdWidth'(ring_store[head_slot]);
          head_slot = wrap_next(head_slot);
          held_count--;
          peek_slot = head_slot;
          peekable_count = held_count;
          r.ok = 1'b1;
        end
      end
      ModePeek: begin
        if (peekable_count != '0) begin
          r.read_data = RdWidth'(ring_store[peek_slot]);
          peek_slot = wrap_next(peek_slot);
          peekable_count--;
          r.ok = 1'b1;
        end
      end
      ModeCommit: begin
        head_slot = peek_slot;
        held_count = peekable_count;
        r.ok = 1'b1;
      end
      ModeRewind: begin
        peek_slot = head_slot;
        peekable_count = held_count;
        r.ok = 1'b1;
      end
      ModeQuery: begin
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.length = LenWidth'(held_count);
    return r;
  endfunction

  // Offer one operation word, with random idle cycles first, and record its result.
  task automatic send_op(input logic [ModeWidth-1:0] mode, input logic [DataWidth-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      op_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    op_if.valid      <= 1'b1;
    op_if.mode       <= mode;
    op_if.write_data <= data;
    do begin
      @(posedge clk_i);
    end while (!op_if.ready);
    awaited_results.push_back(apply_queue_op(mode, data));
    ops_sent++;
  endtask

  // Called in the step of the last acceptance, so valid gets one assignment there.
  task automatic stop_input();
    op_if.valid <= 1'b0;
  endtask

  // Wait until every result word is back, then let the pipeline settle.
  task automatic wait_drained();
    while (awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of the depth register: setup cycle, then access cycle.
  task automatic write_depth_reg(input logic [PdataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DepthRegAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    take_depth_write(value);
    depth_writes++;
  endtask

  // Compare one result word with the oldest prediction.
  task automatic check_result_word();
    result_t want;
    if (awaited_results.size() == 0) begin
      $error("result word with no operation outstanding: ok %0d data %08h length %0d",
             res_if.ok, res_if.read_data, res_if.length);
      failures++;
    end else begin
      want = awaited_results.pop_front();
      words_checked++;
      if (res_if.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, res_if.ok);
        failures++;
      end
      if (res_if.read_data !== want.read_data) begin
        $error("read_data: expected %08h, got %08h", want.read_data, res_if.read_data);
        failures++;
      end
      if (res_if.length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, res_if.length);
        failures++;
      end
    end
  endtask

  // Result side: check accepted words and drive ready, with an optional long hold-off.
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left    = 0;
    hold_seen    = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        check_result_word();
      end
      if (hold_off_req && !hold_seen) begin
        hold_left = HoldOffCycles;
        hold_seen = 1'b1;
      end
      if (!hold_off_req) begin
        hold_seen = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Empty-queue rejects, peek and commit, rewind, and the spare modes at full depth.
  task automatic test_directed_ops();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_op(ModeQuery, 32'h0000_0000);
    send_op(ModeDequeue, 32'hFFFF_FFFF);
    send_op(ModePeek, 32'h0000_0000);
    send_op(ModeEnqueue, 32'h0000_0000);
    send_op(ModeEnqueue, 32'hFFFF_FFFF);
    send_op(ModeEnqueue, 32'h5A5A_A5A5);
    send_op(ModePeek, 32'h0000_0000);
    send_op(ModePeek, 32'hFFFF_FFFF);
    send_op(ModeCommit, 32'h0000_0000);
    send_op(ModeRewind, 32'h0000_0000);
    send_op(ModePeek, 32'h0000_0000);
    send_op(ModeRewind, 32'hFFFF_FFFF);
    send_op(ModeDequeue, 32'h0000_0000);
    send_op(ModeDequeue, 32'h0000_0000);
    send_op(ModeSpareLow, 32'hFFFF_FFFF);
    send_op(ModeSpareHigh, 32'h1234_5678);
    stop_input();
  endtask

  // Smallest depth through a zero write, the full queue, and an oversized write.
  task automatic test_depth_extremes();
    wait_drained();
    write_depth_reg(32'd0);
    send_op(ModeEnqueue, 32'h1234_5678);
    send_op(ModeEnqueue, 32'h8765_4321);
    send_op(ModePeek, 32'h0000_0000);
    send_op(ModePeek, 32'h0000_0000);
    send_op(ModeCommit, 32'h0000_0000);
    send_op(ModeDequeue, 32'h0000_0000);
    send_op(ModeQuery, 32'h0000_0000);
    stop_input();
    wait_drained();
    write_depth_reg(32'd17);
    send_op(ModeEnqueue, 32'hDEAD_BEEF);
    send_op(ModeQuery, 32'h0000_0000);
    stop_input();
  endtask

  // Random traffic built mostly from fill bursts, peek runs and drain bursts.
  task automatic run_random_ops(input int total);
    int sent_here;
    int kind;
    int reps;
    sent_here = 0;
    while (sent_here < total) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        reps = $urandom_range(1, int'(ring_depth) + 1);
        repeat (reps) send_op(ModeEnqueue, $urandom());
        sent_here += reps;
      end else if (kind < 55) begin
        reps = $urandom_range(1, 4);
        repeat (reps) send_op(ModePeek, $urandom());
        send_op($urandom_range(1) ? ModeCommit : ModeRewind, $urandom());
        sent_here += reps + 1;
      end else if (kind < 80) begin
        reps = $urandom_range(1, int'(ring_depth) + 1);
        repeat (reps) send_op(ModeDequeue, $urandom());
        sent_here += reps;
      end else begin
        send_op(ModeWidth'($urandom_range(7)), $urandom());
        sent_here++;
      end
    end
    stop_input();
  endtask

  task automatic test_random_phase(input logic [PdataWidth-1:0] depth_value,
                                   input int send_pct, input int recv_pct, input int total);
    wait_drained();
    write_depth_reg(depth_value);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    run_random_ops(total);
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    wait_drained();
    write_depth_reg(32'd16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req <= 1'b1;
    run_random_ops(40);
    hold_off_req <= 1'b0;
  endtask

  // Stimulus sequence.
  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    op_if.valid      = 1'b0;
    op_if.mode       = ModeQuery;
    op_if.write_data = '0;
    hold_off_req     = 1'b0;
    failures         = 0;
    ops_sent         = 0;
    words_checked    = 0;
    depth_writes     = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    ring_depth       = CntWidth'(Depth);
    empty_ring();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ops();
    test_depth_extremes();
    test_random_phase(32'd16, 15, 59, 500);
    test_random_phase(32'd3, 59, 15, 250);
    test_random_phase(32'd31, 59, 15, 250);
    test_backpressure();
    test_random_phase(32'd1, 0, 0, 150);
    test_random_phase(32'd9, 0, 0, 350);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d result words never arrived", awaited_results.size());
      failures++;
    end
    $display("Sent %0d operation words across %0d depth settings; checked %0d result words.",
             ops_sent, depth_writes, words_checked);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rfpc_pkg.sv
hw/rtl/rfpc_if.sv
hw/rtl/rfpc_regs.sv
hw/rtl/rfpc_core.sv
hw/rtl/ring_fifo_with_peek_commit_top.sv
verif/ring_fifo_with_peek_commit_top_tb.sv
